// File: design/rpa_pkg.sv
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types and codes for the reference-counted page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package rpa_pkg;

    // default sizing
    localparam int PAGE_COUNT_DEF = 32768;
    localparam int COUNT_BITS_DEF = 16;

    // fixed field widths
    localparam int PAGE_W   = 15;
    localparam int FIRST_W  = 15;
    localparam int END_W    = 16;
    localparam int REQ_W    = 3;
    localparam int STAT_W   = 3;
    localparam int CNTOUT_W = 16;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INC   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEC   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_GET   = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_OOM     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_BAD     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_UNDER   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NONZERO = 3'd4;
    localparam logic [STAT_W-1:0] STAT_OVER    = 3'd5;
    localparam logic [STAT_W-1:0] STAT_FULL    = 3'd6;

    // register indexes
    localparam logic REG_FIRST_PAGE = 1'b0;
    localparam logic REG_END_PAGE   = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_POP,
        S_CNT
    } rpa_state_t;

endpackage

`default_nettype wire

// File: design/rpa_ram.sv
// ----------------------------------------------------------------------------
// rpa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/refcounted_page_allocator.sv
// ----------------------------------------------------------------------------
// refcounted_page_allocator
// Page-frame allocator with a reference count per page, LIFO reuse of freed
// pages and fresh pages taken from the top of the managed range downward.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_stall    req_type, page
//  out       output     out_valid / out_stall  status, page_out, count, released
//  cfg       input      cfg_we                 cfg_index, cfg_wdata
//
//  ref requests accept the beat with a count read, then update and post the
//  result; alloc reads the free stack on accept and picks its page before
//  the count read; an alloc that runs out of memory posts its result there.
//  after reset a clearing pass writes zero to every entry of the count
//  memory, with in_stall held high; config writes are taken throughout.
//  a beat may be accepted while the previous result waits on out_stall;
//  the sequencer then holds in its last step until the output frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_page_allocator #(
    parameter int PAGE_COUNT = rpa_pkg::PAGE_COUNT_DEF,
    parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request channel
    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire logic [rpa_pkg::REQ_W-1:0]     req_type,
    input  wire logic [rpa_pkg::PAGE_W-1:0]    page,
    // result channel
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      logic [rpa_pkg::STAT_W-1:0]    status,
    output      logic [rpa_pkg::PAGE_W-1:0]    page_out,
    output      logic [rpa_pkg::CNTOUT_W-1:0]  count,
    output      logic                          released,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [rpa_pkg::END_W-1:0]     cfg_wdata
);

    localparam int AW = $clog2(PAGE_COUNT);
    localparam int TW = (AW + 1 > rpa_pkg::END_W) ? AW + 1 : rpa_pkg::END_W;
    localparam logic [TW-1:0]         PAGES_T   = TW'(PAGE_COUNT);
    localparam logic [AW:0]           PAGES_D   = (AW + 1)'(PAGE_COUNT);
    localparam logic [AW-1:0]         LAST_ADDR = AW'(PAGE_COUNT - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);

    // control and datapath registers
    rpa_pkg::rpa_state_t state_reg, state_next;
    logic [AW-1:0]                 clr_reg, clr_next;
    logic [AW:0]                   depth_reg, depth_next;
    logic [AW:0]                   fresh_reg, fresh_next;
    logic [rpa_pkg::FIRST_W-1:0]   first_page_reg;
    logic [rpa_pkg::END_W-1:0]     end_page_reg;
    logic [rpa_pkg::REQ_W-1:0]     req_reg, req_next;
    logic [rpa_pkg::PAGE_W-1:0]    pg_reg, pg_next;
    logic [AW-1:0]                 addr_reg, addr_next;
    logic                          rng_reg, rng_next;
    logic                          out_valid_reg, out_valid_next;
    logic [rpa_pkg::STAT_W-1:0]    status_reg, status_next;
    logic [rpa_pkg::PAGE_W-1:0]    page_out_reg, page_out_next;
    logic [rpa_pkg::CNTOUT_W-1:0]  count_reg, count_next;
    logic                          released_reg, released_next;

    // memory ports
    logic                  cnt_we, cnt_re;
    logic [AW-1:0]         cnt_waddr, cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
    logic                  stk_we, stk_re;
    logic [AW-1:0]         stk_waddr, stk_raddr;
    logic [AW-1:0]         stk_wdata, stk_rdata;

    // range arithmetic
    logic [TW-1:0] top;
    logic [TW-1:0] size;
    logic [TW-1:0] page_t;
    logic          in_rng;
    logic          fresh_avail;
    logic [AW-1:0] cand_fresh;
    logic          out_free;

    // per-page reference counts
    rpa_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (PAGE_COUNT)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // stack of freed pages
    rpa_ram #(
        .WIDTH (AW),
        .DEPTH (PAGE_COUNT)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // effective top, range check and next fresh page
    always_comb
    begin
        top         = (TW'(end_page_reg) < PAGES_T) ? TW'(end_page_reg) : PAGES_T;
        size        = (TW'(first_page_reg) < top) ? top - TW'(first_page_reg) : '0;
        page_t      = TW'(page);
        in_rng      = (page_t >= TW'(first_page_reg)) && (page_t < top);
        fresh_avail = TW'(fresh_reg) < size;
        cand_fresh  = AW'(top - TW'(1) - TW'(fresh_reg));
        out_free    = !out_valid_reg || !out_stall;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_page_reg <= '0;
            end_page_reg   <= 16'h8000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rpa_pkg::REG_FIRST_PAGE: first_page_reg <= cfg_wdata[rpa_pkg::FIRST_W-1:0];
                rpa_pkg::REG_END_PAGE:   end_page_reg   <= cfg_wdata;
                default:                 end_page_reg   <= cfg_wdata;
            endcase
        end
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rpa_pkg::S_CLEAR;
            clr_reg       <= '0;
            depth_reg     <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            depth_reg     <= depth_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        pg_reg       <= pg_next;
        addr_reg     <= addr_next;
        rng_reg      <= rng_next;
        status_reg   <= status_next;
        page_out_reg <= page_out_next;
        count_reg    <= count_next;
        released_reg <= released_next;
    end

    // sequencer: read, modify, write back
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        depth_next     = depth_reg;
        fresh_next     = fresh_reg;
        req_next       = req_reg;
        pg_next        = pg_reg;
        addr_next      = addr_reg;
        rng_next       = rng_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        page_out_next  = page_out_reg;
        count_next     = count_reg;
        released_next  = released_reg;

        cnt_we    = 1'b0;
        cnt_waddr = addr_reg;
        cnt_wdata = '0;
        cnt_re    = 1'b0;
        cnt_raddr = AW'(page);
        stk_we    = 1'b0;
        stk_waddr = depth_reg[AW-1:0];
        stk_wdata = addr_reg;
        stk_re    = 1'b0;
        stk_raddr = AW'(depth_reg - (AW + 1)'(1));

        case (state_reg)
            // zero the count memory one entry a cycle
            rpa_pkg::S_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = rpa_pkg::S_IDLE;
                end
            end

            // take a beat and launch the first read
            rpa_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next  = req_type;
                    pg_next   = page;
                    addr_next = AW'(page);
                    rng_next  = in_rng;
                    if (req_type == rpa_pkg::REQ_ALLOC)
                    begin
                        stk_re     = 1'b1;
                        state_next = rpa_pkg::S_POP;
                    end
                    else
                    begin
                        cnt_re     = 1'b1;
                        state_next = rpa_pkg::S_CNT;
                    end
                end
            end

            // alloc: pick the candidate, stack first, then fresh, else report out of memory
            rpa_pkg::S_POP:
            begin
                if (depth_reg != '0)
                begin
                    addr_next  = stk_rdata;
                    depth_next = depth_reg - (AW + 1)'(1);
                    cnt_re     = 1'b1;
                    cnt_raddr  = stk_rdata;
                    state_next = rpa_pkg::S_CNT;
                end
                else if (fresh_avail)
                begin
                    addr_next  = cand_fresh;
                    fresh_next = fresh_reg + (AW + 1)'(1);
                    cnt_re     = 1'b1;
                    cnt_raddr  = cand_fresh;
                    state_next = rpa_pkg::S_CNT;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = rpa_pkg::STAT_OOM;
                    page_out_next  = '0;
                    count_next     = '0;
                    released_next  = 1'b0;
                    state_next     = rpa_pkg::S_IDLE;
                end
            end

            // count is back: update and post the result
            rpa_pkg::S_CNT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    released_next  = 1'b0;
                    page_out_next  = pg_reg;
                    status_next    = rpa_pkg::STAT_OK;
                    count_next     = rpa_pkg::CNTOUT_W'(cnt_rdata);
                    state_next     = rpa_pkg::S_IDLE;
                    if (req_reg == rpa_pkg::REQ_ALLOC)
                    begin
                        page_out_next = rpa_pkg::PAGE_W'(addr_reg);
                        if (cnt_rdata != '0)
                        begin
                            status_next = rpa_pkg::STAT_NONZERO;
                        end
                        else
                        begin
                            cnt_we     = 1'b1;
                            cnt_wdata  = CNT_ONE;
                            count_next = rpa_pkg::CNTOUT_W'(CNT_ONE);
                        end
                    end
                    else if (!rng_reg)
                    begin
                        status_next = rpa_pkg::STAT_BAD;
                        count_next  = '0;
                    end
                    else
                    begin
                        case (req_reg)
                            rpa_pkg::REQ_FREE:
                            begin
                                if (cnt_rdata == '0)
                                begin
                                    status_next = rpa_pkg::STAT_UNDER;
                                end
                                else if (cnt_rdata == CNT_ONE)
                                begin
                                    if (depth_reg >= PAGES_D)
                                    begin
                                        status_next = rpa_pkg::STAT_FULL;
                                    end
                                    else
                                    begin
                                        cnt_we        = 1'b1;
                                        cnt_wdata     = '0;
                                        stk_we        = 1'b1;
                                        depth_next    = depth_reg + (AW + 1)'(1);
                                        count_next    = '0;
                                        released_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    cnt_we     = 1'b1;
                                    cnt_wdata  = cnt_rdata - CNT_ONE;
                                    count_next = rpa_pkg::CNTOUT_W'(cnt_rdata - CNT_ONE);
                                end
                            end
                            rpa_pkg::REQ_INC:
                            begin
                                if (cnt_rdata == CNT_MAX)
                                begin
                                    status_next = rpa_pkg::STAT_OVER;
                                end
                                else
                                begin
                                    cnt_we     = 1'b1;
                                    cnt_wdata  = cnt_rdata + CNT_ONE;
                                    count_next = rpa_pkg::CNTOUT_W'(cnt_rdata + CNT_ONE);
                                end
                            end
                            rpa_pkg::REQ_DEC:
                            begin
                                if (cnt_rdata == '0)
                                begin
                                    status_next = rpa_pkg::STAT_UNDER;
                                end
                                else
                                begin
                                    cnt_we     = 1'b1;
                                    cnt_wdata  = cnt_rdata - CNT_ONE;
                                    count_next = rpa_pkg::CNTOUT_W'(cnt_rdata - CNT_ONE);
                                end
                            end
                            default:
                            begin
                                status_next = rpa_pkg::STAT_OK;
                            end
                        endcase
                    end
                end
            end

            default:
            begin
                state_next = rpa_pkg::S_IDLE;
            end
        endcase
    end

    // ports
    assign in_stall  = (state_reg != rpa_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign page_out  = page_out_reg;
    assign count     = count_reg;
    assign released  = released_reg;

`ifndef SYNTHESIS
    // one request in flight: an accepted beat blocks the next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while another is in flight");

    // stack never grows past its depth
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= PAGES_D)
        else $error("free stack depth out of bounds");

    // fresh pages handed out never exceed the page count
    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= PAGES_D)
        else $error("fresh page counter out of bounds");

    // a release is always a successful beat with a zero count
    a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && released) |-> (status == rpa_pkg::STAT_OK && count == '0))
        else $error("release reported with bad status or count");

    // the stack only moves in the pop and count steps of a request
    a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rpa_pkg::S_IDLE || state_reg == rpa_pkg::S_CLEAR)
        |=> $stable(depth_reg))
        else $error("stack depth changed outside a request");
`endif

endmodule

`default_nettype wire

// File: verif/tb_refcounted_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_refcounted_page_allocator
// Self-checking bench for the page allocator. Requests are queued by the
// stimulus process, sent by a clocked driver and scored against an in-bench
// model of the page pool: free stack, fresh-page cursor and per-page counts.
// Covers directed corner cases, random traffic over several managed ranges
// and a long output hold-off that backs up the request channel.
// ----------------------------------------------------------------------------

module tb_refcounted_page_allocator;

    localparam int CNT_MAX     = (1 << rpa_pkg::COUNT_BITS_DEF) - 1;
    localparam int DRAIN_WAIT  = 12;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int MAX_PRINTS  = 100;
    localparam int RAND_ITEMS  = 473;
    // unused request codes, handled as get
    localparam logic [rpa_pkg::REQ_W-1:0] REQ_SPARE_LO =
        rpa_pkg::REQ_GET + rpa_pkg::REQ_W'(1);
    localparam logic [rpa_pkg::REQ_W-1:0] REQ_SPARE_HI = '1;

    typedef struct packed {
        logic [rpa_pkg::REQ_W-1:0]  req;
        logic [rpa_pkg::PAGE_W-1:0] pg;
    } page_req_t;

    typedef struct packed {
        logic [rpa_pkg::STAT_W-1:0]   status;
        logic [rpa_pkg::PAGE_W-1:0]   page_out;
        logic [rpa_pkg::CNTOUT_W-1:0] count;
        logic                         released;
    } page_result_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // dut ports
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic [rpa_pkg::REQ_W-1:0]     req_type  = '0;
    logic [rpa_pkg::PAGE_W-1:0]    page      = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [rpa_pkg::STAT_W-1:0]    status;
    logic [rpa_pkg::PAGE_W-1:0]    page_out;
    logic [rpa_pkg::CNTOUT_W-1:0]  count;
    logic                          released;
    logic                          cfg_we    = 1'b0;
    logic                          cfg_index = 1'b0;
    logic [rpa_pkg::END_W-1:0]     cfg_wdata = '0;

    // pool model
    logic [rpa_pkg::CNTOUT_W-1:0] page_refs [rpa_pkg::PAGE_COUNT_DEF] = '{default: '0};
    logic [rpa_pkg::PAGE_W-1:0]   free_pages [rpa_pkg::PAGE_COUNT_DEF];
    int                           free_depth  = 0;
    int                           fresh_count = 0;
    int                           pool_first  = 0;
    int                           pool_end    = rpa_pkg::PAGE_COUNT_DEF;

    // bench bookkeeping
    page_req_t    req_q[$];
    page_result_t expected_q[$];
    page_req_t    next_beat;
    page_result_t want;
    int           err_count = 0;
    int           cycle_cnt = 0;
    int           send_idle = 0;
    int           recv_idle = 0;
    logic         hold_req  = 1'b0;
    logic         hold_done = 1'b0;
    int           hold_left = 0;

    refcounted_page_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .page      (page),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .page_out  (page_out),
        .count     (count),
        .released  (released),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // apply one request to the pool model and return its result
    function automatic page_result_t pool_apply(input logic [rpa_pkg::REQ_W-1:0] req,
                                                input logic [rpa_pkg::PAGE_W-1:0] pg);
        page_result_t r;
        int top;
        int span;
        logic [rpa_pkg::PAGE_W-1:0] cand;
        int cur;
        r   = '0;
        top = (pool_end < rpa_pkg::PAGE_COUNT_DEF) ? pool_end : rpa_pkg::PAGE_COUNT_DEF;
        if (req == rpa_pkg::REQ_ALLOC)
        begin
            // stack first, then next fresh page from the top down
            if (free_depth > 0)
            begin
                free_depth--;
                cand = free_pages[free_depth[rpa_pkg::PAGE_W-1:0]];
            end
            else
            begin
                span = (pool_first < top) ? top - pool_first : 0;
                if (fresh_count >= span)
                begin
                    r.status = rpa_pkg::STAT_OOM;
                    return r;
                end
                cand = rpa_pkg::PAGE_W'(top - 1 - fresh_count);
                fresh_count++;
            end
            r.page_out = cand;
            if (page_refs[cand] != '0)
            begin
                r.status = rpa_pkg::STAT_NONZERO;
                r.count  = page_refs[cand];
            end
            else
            begin
                page_refs[cand] = rpa_pkg::CNTOUT_W'(1);
                r.status        = rpa_pkg::STAT_OK;
                r.count         = rpa_pkg::CNTOUT_W'(1);
            end
            return r;
        end
        r.page_out = pg;
        if (int'(pg) < pool_first || int'(pg) >= top)
        begin
            r.status = rpa_pkg::STAT_BAD;
            return r;
        end
        cur = int'(page_refs[pg]);
        case (req)
            rpa_pkg::REQ_FREE:
            begin
                if (cur == 0)
                    r.status = rpa_pkg::STAT_UNDER;
                else if (cur == 1)
                begin
                    if (free_depth >= rpa_pkg::PAGE_COUNT_DEF)
                    begin
                        r.status = rpa_pkg::STAT_FULL;
                        r.count  = rpa_pkg::CNTOUT_W'(cur);
                    end
                    else
                    begin
                        page_refs[pg] = '0;
                        free_pages[free_depth[rpa_pkg::PAGE_W-1:0]] = pg;
                        free_depth++;
                        r.released = 1'b1;
                    end
                end
                else
                begin
                    page_refs[pg] = rpa_pkg::CNTOUT_W'(cur - 1);
                    r.count       = rpa_pkg::CNTOUT_W'(cur - 1);
                end
            end
            rpa_pkg::REQ_INC:
            begin
                if (cur >= CNT_MAX)
                begin
                    r.status = rpa_pkg::STAT_OVER;
                    r.count  = rpa_pkg::CNTOUT_W'(cur);
                end
                else
                begin
                    page_refs[pg] = rpa_pkg::CNTOUT_W'(cur + 1);
                    r.count       = rpa_pkg::CNTOUT_W'(cur + 1);
                end
            end
            rpa_pkg::REQ_DEC:
            begin
                if (cur == 0)
                    r.status = rpa_pkg::STAT_UNDER;
                else
                begin
                    page_refs[pg] = rpa_pkg::CNTOUT_W'(cur - 1);
                    r.count       = rpa_pkg::CNTOUT_W'(cur - 1);
                end
            end
            // get and the unused codes
            default: r.count = rpa_pkg::CNTOUT_W'(cur);
        endcase
        return r;
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("%0t ERROR %s", $time, msg);
    endtask

    // request driver: predicts on every accepted beat
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                expected_q.push_back(pool_apply(req_type, page));
            if (!in_valid || !in_stall)
            begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    next_beat = req_q.pop_front();
                    in_valid <= 1'b1;
                    req_type <= next_beat.req;
                    page     <= next_beat.pg;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stall plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
                flag_error($sformatf("result beat with nothing outstanding, page_out %0d",
                                     page_out));
            else
            begin
                want = expected_q.pop_front();
                if (status !== want.status)
                    flag_error($sformatf("status got %0d want %0d (page %0d)",
                                         status, want.status, want.page_out));
                if (page_out !== want.page_out)
                    flag_error($sformatf("page_out got %0d want %0d",
                                         page_out, want.page_out));
                if (count !== want.count)
                    flag_error($sformatf("count got %0d want %0d (page %0d)",
                                         count, want.count, want.page_out));
                if (released !== want.released)
                    flag_error($sformatf("released got %0b want %0b (page %0d)",
                                         released, want.released, want.page_out));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_req(input logic [rpa_pkg::REQ_W-1:0] req, input int pg);
        page_req_t item;
        item.req = req;
        item.pg  = pg[rpa_pkg::PAGE_W-1:0];
        req_q.push_back(item);
    endtask

    // block until every request is sent and every result is back
    task automatic wait_drained();
        while (req_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[rpa_pkg::END_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_range(input int first, input int last);
        wait_drained();
        write_reg(rpa_pkg::REG_FIRST_PAGE, first);
        write_reg(rpa_pkg::REG_END_PAGE, last);
        pool_first = first & ((1 << rpa_pkg::FIRST_W) - 1);
        pool_end   = last;
    endtask

    // random traffic mostly inside the managed range, some anywhere
    task automatic queue_random(input int n, input int lo, input int hi);
        int pick;
        int pg;
        logic [rpa_pkg::REQ_W-1:0] req;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 28)
                req = rpa_pkg::REQ_ALLOC;
            else if (pick < 48)
                req = rpa_pkg::REQ_FREE;
            else if (pick < 68)
                req = rpa_pkg::REQ_INC;
            else if (pick < 83)
                req = rpa_pkg::REQ_DEC;
            else if (pick < 95)
                req = rpa_pkg::REQ_GET;
            else
                req = rpa_pkg::REQ_W'($urandom_range(int'(REQ_SPARE_HI),
                                                     int'(REQ_SPARE_LO)));
            if ($urandom_range(99) < 85)
                pg = $urandom_range(hi - 1, lo);
            else
                pg = $urandom_range((1 << rpa_pkg::PAGE_W) - 1);
            push_req(req, pg);
        end
    endtask

    // stimulus and end of run
    initial
    begin
        send_idle = 38;
        recv_idle = 79;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: four-page range, exhaustion, reuse and error codes
        set_range(100, 104);
        @(negedge clk);
        repeat (5) push_req(rpa_pkg::REQ_ALLOC, 0);
        push_req(rpa_pkg::REQ_INC, 103);
        push_req(rpa_pkg::REQ_FREE, 103);
        push_req(rpa_pkg::REQ_FREE, 103);
        push_req(rpa_pkg::REQ_FREE, 103);
        push_req(rpa_pkg::REQ_DEC, 103);
        push_req(rpa_pkg::REQ_GET, 99);
        push_req(rpa_pkg::REQ_INC, 104);
        push_req(rpa_pkg::REQ_DEC, 102);
        push_req(rpa_pkg::REQ_ALLOC, 0);
        push_req(rpa_pkg::REQ_ALLOC, 0);
        push_req(rpa_pkg::REQ_INC, 102);
        push_req(rpa_pkg::REQ_FREE, 102);
        push_req(rpa_pkg::REQ_INC, 102);
        push_req(rpa_pkg::REQ_ALLOC, 0);
        push_req(REQ_SPARE_HI, 101);
        push_req(REQ_SPARE_LO, 32767);
        push_req(REQ_SPARE_LO + rpa_pkg::REQ_W'(1), 100);

        // empty range
        set_range(1000, 1000);
        @(negedge clk);
        push_req(rpa_pkg::REQ_ALLOC, 0);
        push_req(rpa_pkg::REQ_GET, 1000);

        // highest single page
        set_range(32767, 32768);
        @(negedge clk);
        push_req(rpa_pkg::REQ_INC, 32767);
        push_req(rpa_pkg::REQ_GET, 32766);
        push_req(rpa_pkg::REQ_FREE, 32767);

        // lowest single page; the stacked page is handed out anyway
        set_range(0, 1);
        @(negedge clk);
        push_req(rpa_pkg::REQ_ALLOC, 0);
        push_req(rpa_pkg::REQ_GET, 0);
        push_req(rpa_pkg::REQ_GET, 1);

        // random, sender idles less than receiver
        set_range(200, 232);
        @(negedge clk);
        queue_random(RAND_ITEMS, 200, 232);

        // random, receiver idles less than sender
        set_range(0, 64);
        @(negedge clk);
        send_idle = 79;
        recv_idle = 38;
        queue_random(RAND_ITEMS, 0, 64);

        // random, no idling, with a long output hold-off
        set_range(32640, 32767);
        @(negedge clk);
        send_idle = 0;
        recv_idle = 0;
        queue_random(RAND_ITEMS, 32640, 32767);
        hold_req = 1'b1;

        wait_drained();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
